>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker module of this project.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in every cycle outside reset.
`define KCPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication that the consequent holds in the cycle after the antecedent.
`define KCPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication.
`define KCPS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/core/kcps_pkg.sv
// Shared types and constants for the k-closest-points selector.
// No dependencies.
`default_nettype none

package kcps_pkg;

   localparam int COORD_W = 16;
   localparam int DIST_W  = 32;
   localparam int CSR_W   = 5;

   // One kept point; distance in the upper half so the layout matches the store word.
   typedef struct packed {
      logic [DIST_W-1:0]         distance;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } entry_type;

   // Operation broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic emit;
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> rtl/core/kcps_dist.sv
// Two-stage squared-distance unit: squares in the first stage, sum in the second.
// Depends on kcps_pkg.
`default_nettype none

module kcps_dist import kcps_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire logic signed [COORD_W-1:0] in_x,
   input  wire logic signed [COORD_W-1:0] in_y,
   input  wire logic                      in_last,
   output logic                           out_valid,
   output logic                           out_last,
   output entry_type                      out_entry
);

   logic                      valid1_ff, valid2_ff;
   logic                      last1_ff, last2_ff;
   logic signed [COORD_W-1:0] x1_ff, y1_ff;
   logic signed [DIST_W-1:0]  sqx_ff, sqy_ff;
   logic signed [DIST_W-1:0]  sqx_in, sqy_in;
   logic [DIST_W-1:0]         sum_in;
   entry_type                 entry2_ff;

   // Each square is at most 2^30, so the signed product is exact in 32 bits.
   assign sqx_in = in_x * in_x;
   assign sqy_in = in_y * in_y;
   assign sum_in = DIST_W'($unsigned(sqx_ff)) + DIST_W'($unsigned(sqy_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
      last1_ff           <= in_last;
      x1_ff              <= in_x;
      y1_ff              <= in_y;
      sqx_ff             <= sqx_in;
      sqy_ff             <= sqy_in;
      last2_ff           <= last1_ff;
      entry2_ff.x        <= x1_ff;
      entry2_ff.y        <= y1_ff;
      entry2_ff.distance <= sum_in;
   end

   assign out_valid = valid2_ff;
   assign out_last  = last2_ff;
   assign out_entry = entry2_ff;

endmodule

`default_nettype wire

>>> rtl/core/kcps_cell.sv
// One cell of the sorted-insert chain: holds one kept point.
// On insert it keeps, takes the new point or takes its lower neighbor's point;
// on emit it takes its upper neighbor's point. Depends on kcps_pkg.
`default_nettype none

module kcps_cell import kcps_pkg::*; (
   input  wire logic         clock,
   input  wire cell_ctl_type ctl,
   input  wire logic         valid,
   input  wire entry_type    new_entry,
   input  wire entry_type    prev_entry,
   input  wire logic         prev_shift,
   input  wire entry_type    next_entry,
   output entry_type         entry,
   output logic              shift
);

   entry_type entry_ff, entry_in;

   // A valid cell farther than the new point moves one place down the chain.
   assign shift = valid && (entry_ff.distance > new_entry.distance);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.emit) begin
         entry_in = next_entry;
      end else if (ctl.insert) begin
         if (prev_shift) begin
            entry_in = prev_entry;
         end else if (shift || !valid) begin
            entry_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

>>> rtl/core/k_closest_points_select_top.sv
// Results: the last point of a set is squared, summed and inserted as emit is set;
// the results then follow on consecutive cycles, nearest first.
// Throughput: one point per cycle inside a set, set by the insert chain taking one
// point per cycle; busy stays high from the last point until the final result.
// Reset: synchronous; empties the store, sets keep_count to 1, clears busy.
`default_nettype none

module k_closest_points_select_top import kcps_pkg::*; #(
   parameter int MAX_KEEP = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic signed [COORD_W-1:0] req_x_coord,
   input  wire logic signed [COORD_W-1:0] req_y_coord,
   input  wire logic                      req_last_point,
   output logic                           rsp_valid,
   output logic signed [COORD_W-1:0]      rsp_out_x,
   output logic signed [COORD_W-1:0]      rsp_out_y,
   output logic [DIST_W-1:0]              rsp_squared_distance,
   output logic                           rsp_last_result,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_W-1:0]          csr_keep_count
);

   localparam int CNT_W = $clog2(MAX_KEEP + 1);

   logic [CSR_W-1:0] keep_count_ff;
   logic [CNT_W-1:0] k_eff, n_eff, n_next;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             busy_ff, busy_in;
   logic             emit_ff, emit_in;
   logic             accept;

   logic             dist_valid, dist_last;
   entry_type        dist_entry;
   cell_ctl_type     ctl;

   entry_type        cell_entry [MAX_KEEP];
   logic [MAX_KEEP-1:0] cell_shift;
   logic [MAX_KEEP-1:0] cell_valid;

   assign accept    = start && !busy_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff <= CSR_W'(1);
      end else if (csr_valid && csr_ready) begin
         keep_count_ff <= csr_keep_count;
      end
   end

   always_comb begin
      if (keep_count_ff == '0) begin
         k_eff = CNT_W'(1);
      end else if (32'(keep_count_ff) > 32'(MAX_KEEP)) begin
         k_eff = CNT_W'(MAX_KEEP);
      end else begin
         k_eff = CNT_W'(keep_count_ff);
      end
   end

   assign n_eff  = (count_ff < k_eff) ? count_ff : k_eff;
   assign n_next = (n_eff < k_eff) ? n_eff + CNT_W'(1) : n_eff;

   kcps_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_x      (req_x_coord),
      .in_y      (req_y_coord),
      .in_last   (req_last_point),
      .out_valid (dist_valid),
      .out_last  (dist_last),
      .out_entry (dist_entry)
   );

   assign ctl.insert = dist_valid;
   assign ctl.emit   = emit_ff;

   for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
      entry_type prev_e, next_e;
      logic      prev_s;

      assign cell_valid[i] = n_eff > CNT_W'(i);

      if (i == 0) begin : g_first
         assign prev_e = dist_entry;
         assign prev_s = 1'b0;
      end else begin : g_mid
         assign prev_e = cell_entry[i-1];
         assign prev_s = cell_shift[i-1];
      end

      if (i == MAX_KEEP - 1) begin : g_end
         assign next_e = cell_entry[i];
      end else begin : g_inner
         assign next_e = cell_entry[i+1];
      end

      kcps_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .valid      (cell_valid[i]),
         .new_entry  (dist_entry),
         .prev_entry (prev_e),
         .prev_shift (prev_s),
         .next_entry (next_e),
         .entry      (cell_entry[i]),
         .shift      (cell_shift[i])
      );
   end

   always_comb begin
      busy_in   = busy_ff;
      emit_in   = emit_ff;
      count_in  = count_ff;
      remain_in = remain_ff;
      if (accept && req_last_point) begin
         busy_in = 1'b1;
      end
      if (dist_valid) begin
         count_in = n_next;
         if (dist_last) begin
            emit_in   = 1'b1;
            remain_in = n_next;
         end
      end
      if (emit_ff) begin
         remain_in = remain_ff - CNT_W'(1);
         if (remain_ff == CNT_W'(1)) begin
            emit_in  = 1'b0;
            busy_in  = 1'b0;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         emit_ff   <= 1'b0;
         count_ff  <= '0;
         remain_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         emit_ff   <= emit_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
      end
   end

   assign busy                 = busy_ff;
   assign rsp_valid            = emit_ff;
   assign rsp_out_x            = cell_entry[0].x;
   assign rsp_out_y            = cell_entry[0].y;
   assign rsp_squared_distance = cell_entry[0].distance;
   assign rsp_last_result      = emit_ff && (remain_ff == CNT_W'(1));

endmodule

`default_nettype wire

>>> rtl/core/kcps_checker.sv
// Port-level checker for the k-closest-points selector, bound to the top level.
// Depends on kcps_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module kcps_checker import kcps_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire logic              rsp_last_result,
   input wire logic [DIST_W-1:0] rsp_squared_distance
);

   // Results only come out while a set is being reported.
   `KCPS_ASSERT_IMPL(a_rsp_in_busy, clock, reset, rsp_valid, busy, "result outside busy window")

   // A report is one unbroken burst until its final transaction.
   `KCPS_ASSERT_NEXT(a_burst, clock, reset, rsp_valid && !rsp_last_result, rsp_valid, "gap in result burst")

   // The block is free for the next set right after the final result.
   `KCPS_ASSERT_NEXT(a_free_after, clock, reset, rsp_valid && rsp_last_result, !busy && !rsp_valid, "busy after final result")

   // Reported distances never decrease within a burst.
   `KCPS_ASSERT_IMPL(a_sorted, clock, reset, rsp_valid && $past(rsp_valid) && !$past(rsp_last_result), rsp_squared_distance >= $past(rsp_squared_distance), "results out of order")

endmodule

bind k_closest_points_select_top kcps_checker u_kcps_checker (
   .clock                (clock),
   .reset                (reset),
   .busy                 (busy),
   .rsp_valid            (rsp_valid),
   .rsp_last_result      (rsp_last_result),
   .rsp_squared_distance (rsp_squared_distance)
);

`default_nettype wire
